// ----- design/cpg_pkg.sv -----
// Package for the closest-pair grid search block.
// Holds default sizes and the sequencer state type; no dependencies.
package cpg_pkg;
	localparam int GRID_MAX_DEF   = 16;
	localparam int CELL_CAP_DEF   = 8;
	localparam int COORD_BITS_DEF = 16;
	localparam int SIDE_W         = 5;
	localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd16;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_FLUSH,
		ST_CELL,
		ST_CELLW,
		ST_PA,
		ST_PAW,
		ST_NB,
		ST_NBW,
		ST_PB,
		ST_PBW,
		ST_DRAIN,
		ST_ROOT,
		ST_ROOTW,
		ST_OUT
	} cpg_state_t;
endpackage

// ----- design/cpg_if.sv -----
// Valid/ready channel interfaces for point beats and result beats.
// Depends on cpg_pkg.
interface cpg_pt_if import cpg_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] x_coord;
	logic [COORD_BITS-1:0] y_coord;
	logic                  last_point;
	modport source (output valid, x_coord, y_coord, last_point, input ready);
	modport sink (input valid, x_coord, y_coord, last_point, output ready);
endinterface

interface cpg_res_if import cpg_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF);
	logic                valid;
	logic                ready;
	logic [COORD_BITS:0] min_distance;
	logic                pair_found;
	logic                cell_overflow;
	modport source (output valid, min_distance, pair_found, cell_overflow, input ready);
	modport sink (input valid, min_distance, pair_found, cell_overflow, output ready);
endinterface

// ----- design/cpg_cmp.sv -----
// Distance pipeline: absolute difference, squares, sum and running minimum.
// Depends on cpg_pkg.
module cpg_cmp import cpg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    pair_valid,
	input  logic [COORD_BITS-1:0]   ax,
	input  logic [COORD_BITS-1:0]   ay,
	input  logic [COORD_BITS-1:0]   bx,
	input  logic [COORD_BITS-1:0]   by,
	output logic                    busy,
	output logic                    seen,
	output logic [2*COORD_BITS+1:0] best
);
	localparam int C = COORD_BITS;

	logic             v_s1, v_s2;
	logic [C-1:0]     dx_s1, dy_s1;
	logic [2*C-1:0]   sqx_s2, sqy_s2;
	logic [2*C+1:0]   sum;
	logic [2*C+1:0]   best_q;
	logic             seen_q;

	assign sum  = (2*C+2)'(sqx_s2) + (2*C+2)'(sqy_s2);
	assign busy = v_s1 | v_s2;
	assign seen = seen_q;
	assign best = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			seen_q <= 1'b0;
			best_q <= '1;
		end else begin
			v_s1 <= pair_valid;
			v_s2 <= v_s1;
			if (clear) begin
				seen_q <= 1'b0;
				best_q <= '1;
			end else if (v_s2) begin
				seen_q <= 1'b1;
				if (sum < best_q) best_q <= sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= (ax >= bx) ? ax - bx : bx - ax;
		dy_s1  <= (ay >= by) ? ay - by : by - ay;
		sqx_s2 <= dx_s1 * dx_s1;
		sqy_s2 <= dy_s1 * dy_s1;
	end
endmodule

// ----- design/cpg_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle, rounded down.
// Depends on cpg_pkg.
module cpg_isqrt import cpg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [2*COORD_BITS+1:0] radicand,
	output logic                    done,
	output logic [COORD_BITS:0]     root
);
	localparam int C  = COORD_BITS;
	localparam int NB = $clog2(C + 2);

	logic [2*C+1:0] v_q;
	logic [C+3:0]   rem_q;
	logic [C:0]     root_q;
	logic [NB-1:0]  cnt_q;
	logic           run_q, done_q;
	logic [C+3:0]   rem2, trial;

	assign rem2  = {rem_q[C+1:0], v_q[2*C+1:2*C]};
	assign trial = {1'b0, root_q, 2'b01};
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == NB'(C)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			v_q <= {v_q[2*C-1:0], 2'b00};
			if (rem2 >= trial) begin
				rem_q  <= rem2 - trial;
				root_q <= {root_q[C-1:0], 1'b1};
			end else begin
				rem_q  <= rem2;
				root_q <= {root_q[C-1:0], 1'b0};
			end
		end
	end
endmodule

// ----- design/closest_pair_grid_hash.sv -----
// Closest pair by grid hashing: cell fill memory, point memory and search sequencer.
// Point beats: one per cycle while in the load state, two-stage load pipeline with fill forwarding.
// Search, after a flush state: each cell's fill is read (CELL, CELLW); each stored point
// is read (PA, PAW), each in-grid neighbor cell (own cell too) is read (NB, NBW) and its
// pairs compared (PB, PBW); then a drain for the compare and the root before the result beat.
// Reset: async active low; fill valid bits and flags clear, best sets to all ones; point memory is not reset.
// Depends on cpg_pkg, cpg_if, cpg_cmp, cpg_isqrt.
module closest_pair_grid_hash import cpg_pkg::*; #(
	parameter int GRID_MAX   = GRID_MAX_DEF,
	parameter int CELL_CAP   = CELL_CAP_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIDE_W-1:0] cfg_wdata,
	cpg_pt_if.sink            pt_in,
	cpg_res_if.source         res_out
);
	localparam int C     = COORD_BITS;
	localparam int CELLS = GRID_MAX * GRID_MAX;
	localparam int GB    = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
	localparam int CB    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SW    = $clog2(GRID_MAX + 1);
	localparam int FB    = $clog2(CELL_CAP + 1);
	localparam int AB    = (CELLS * CELL_CAP > 1) ? $clog2(CELLS * CELL_CAP) : 1;

	function automatic logic [CB-1:0] cell_idx(input logic [GB-1:0] cx, input logic [GB-1:0] cy);
		return CB'(CB'(cy) * CB'(GRID_MAX) + CB'(cx));
	endfunction

	function automatic logic [AB-1:0] slot_addr(input logic [CB-1:0] c, input logic [FB-1:0] s);
		return AB'(AB'(c) * AB'(CELL_CAP) + AB'(s));
	endfunction

	function automatic logic [GB-1:0] bin(input logic [C-1:0] v, input logic [SW-1:0] side);
		logic [C+SW-1:0] p;
		logic [SW-1:0]   q;
		p = (C+SW)'(v) * (C+SW)'(side);
		q = p[C +: SW];
		return (32'(q) >= GRID_MAX) ? GB'(GRID_MAX - 1) : GB'(q);
	endfunction

	cpg_state_t state_q, state_d;

	logic [SIDE_W-1:0] side_q;
	logic [SW-1:0]     side_use;

	logic [FB-1:0]  fill_mem [CELLS];
	logic [2*C-1:0] pt_mem [CELLS*CELL_CAP];
	logic [CELLS-1:0] fvalid_q;
	logic [CB-1:0]  fill_raddr, fill_raddr_q;
	logic [FB-1:0]  fill_rd, fill_eff;
	logic [AB-1:0]  pt_raddr;
	logic [2*C-1:0] pt_rd;

	logic           v_s1;
	logic [CB-1:0]  cell_s1;
	logic [C-1:0]   x_s1, y_s1;
	logic           wr_vld_q;
	logic [CB-1:0]  wr_cell_q;
	logic [FB-1:0]  wr_fill_q;
	logic [FB-1:0]  load_fill;
	logic           load_wr;
	logic           dropped_q;

	logic [GB-1:0]  cx_q, cy_q;
	logic [1:0]     ox_q, oy_q;
	logic [FB-1:0]  k_q, nk_q, m_q, nf_q;
	logic [CB-1:0]  ncell_q;
	logic [C-1:0]   pax_q, pay_q;
	logic [GB:0]    nxw, nyw;
	logic           nb_in, nb_self, last_cell;
	logic [CB-1:0]  cur_cell, nb_cell;

	logic           cmp_valid, cmp_busy, cmp_seen, cmp_clear;
	logic [2*C+1:0] best;
	logic           root_start, root_done;
	logic [C:0]     root;
	logic [C:0]     dist_q;
	logic           found_q, ovf_q;
	logic           res_hs;

	assign side_use = (side_q == '0) ? SW'(1)
		: ((32'(side_q) > GRID_MAX) ? SW'(GRID_MAX) : SW'(side_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_q <= SIDE_RESET;
		else if (cfg_we) side_q <= cfg_wdata;
	end

	assign pt_in.ready = (state_q == ST_LOAD);
	assign res_hs      = res_out.valid & res_out.ready;
	assign cmp_clear   = res_hs;

	// fill count as seen by the consumer of the registered read
	assign fill_eff  = fvalid_q[fill_raddr_q] ? fill_rd : '0;
	assign load_fill = (wr_vld_q && wr_cell_q == cell_s1) ? wr_fill_q : fill_eff;
	assign load_wr   = v_s1 && (32'(load_fill) < CELL_CAP);

	assign cur_cell  = cell_idx(cx_q, cy_q);
	assign nxw       = (GB+1)'(cx_q) + (GB+1)'(ox_q);
	assign nyw       = (GB+1)'(cy_q) + (GB+1)'(oy_q);
	assign nb_in     = nxw != '0 && nyw != '0 && nxw <= (GB+1)'(GRID_MAX)
		&& nyw <= (GB+1)'(GRID_MAX);
	assign nb_cell   = cell_idx(GB'(nxw - 1'b1), GB'(nyw - 1'b1));
	assign nb_self   = (ox_q == 2'd1) && (oy_q == 2'd1);
	assign last_cell = (cx_q == GB'(GRID_MAX - 1)) && (cy_q == GB'(GRID_MAX - 1));

	always_comb begin
		fill_raddr = cell_idx(bin(pt_in.x_coord, side_use), bin(pt_in.y_coord, side_use));
		if (state_q == ST_CELL) fill_raddr = cur_cell;
		else if (state_q == ST_NB) fill_raddr = nb_cell;
	end

	assign pt_raddr  = (state_q == ST_PA) ? slot_addr(cur_cell, k_q) : slot_addr(ncell_q, m_q);

	always_ff @(posedge clk) begin
		fill_raddr_q <= fill_raddr;
		fill_rd      <= fill_mem[fill_raddr];
		pt_rd        <= pt_mem[pt_raddr];
		if (load_wr) begin
			fill_mem[cell_s1] <= load_fill + 1'b1;
			pt_mem[slot_addr(cell_s1, load_fill)] <= {y_s1, x_s1};
		end
	end

	// load pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			wr_vld_q  <= 1'b0;
			fvalid_q  <= '0;
			dropped_q <= 1'b0;
		end else begin
			v_s1     <= pt_in.valid & pt_in.ready;
			wr_vld_q <= load_wr;
			if (res_hs) begin
				fvalid_q  <= '0;
				dropped_q <= 1'b0;
			end else begin
				if (load_wr) fvalid_q[cell_s1] <= 1'b1;
				if (v_s1 && !load_wr) dropped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cell_s1   <= fill_raddr;
		x_s1      <= pt_in.x_coord;
		y_s1      <= pt_in.y_coord;
		wr_cell_q <= cell_s1;
		wr_fill_q <= load_fill + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		cmp_valid  = 1'b0;
		root_start = 1'b0;
		case (state_q)
			ST_LOAD: if (pt_in.valid && pt_in.last_point) state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_CELL;
			ST_CELL: state_d = ST_CELLW;
			ST_CELLW: begin
				if (fill_eff != '0) state_d = ST_PA;
				else state_d = last_cell ? ST_DRAIN : ST_CELL;
			end
			ST_PA: state_d = ST_PAW;
			ST_PAW: state_d = ST_NB;
			ST_NB: begin
				if (oy_q == 2'd3) begin
					if (k_q + 1'b1 != nk_q) state_d = ST_PA;
					else state_d = last_cell ? ST_DRAIN : ST_CELL;
				end else if (nb_in) begin
					state_d = ST_NBW;
				end
			end
			ST_NBW: state_d = ST_PB;
			ST_PB: state_d = (m_q >= nf_q) ? ST_NB : ST_PBW;
			ST_PBW: begin
				cmp_valid = 1'b1;
				state_d   = ST_PB;
			end
			ST_DRAIN: if (!cmp_busy) state_d = ST_ROOT;
			ST_ROOT: begin
				root_start = 1'b1;
				state_d    = ST_ROOTW;
			end
			ST_ROOTW: if (root_done) state_d = ST_OUT;
			ST_OUT: if (res_out.ready) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	// search counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (state_q == ST_FLUSH) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if ((state_q == ST_CELLW && state_d == ST_CELL)
				|| (state_q == ST_NB && state_d == ST_CELL)) begin
			if (cx_q == GB'(GRID_MAX - 1)) begin
				cx_q <= '0;
				cy_q <= cy_q + 1'b1;
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_CELLW: begin
				nk_q <= fill_eff;
				k_q  <= '0;
			end
			ST_PAW: begin
				pax_q <= pt_rd[C-1:0];
				pay_q <= pt_rd[2*C-1:C];
				ox_q  <= '0;
				oy_q  <= '0;
			end
			ST_NB: begin
				if (oy_q == 2'd3) begin
					k_q <= k_q + 1'b1;
				end else if (nb_in) begin
					ncell_q <= nb_cell;
				end else if (ox_q == 2'd2) begin
					ox_q <= '0;
					oy_q <= oy_q + 1'b1;
				end else begin
					ox_q <= ox_q + 1'b1;
				end
			end
			ST_NBW: begin
				nf_q <= fill_eff;
				m_q  <= nb_self ? k_q + 1'b1 : '0;
			end
			ST_PB: begin
				if (m_q >= nf_q) begin
					if (ox_q == 2'd2) begin
						ox_q <= '0;
						oy_q <= oy_q + 1'b1;
					end else begin
						ox_q <= ox_q + 1'b1;
					end
				end
			end
			ST_PBW: m_q <= m_q + 1'b1;
			ST_ROOTW: begin
				if (root_done) begin
					dist_q  <= cmp_seen ? root : '0;
					found_q <= cmp_seen;
					ovf_q   <= dropped_q;
				end
			end
			default: begin
			end
		endcase
	end

	cpg_cmp #(.COORD_BITS(C)) u_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cmp_clear),
		.pair_valid (cmp_valid),
		.ax         (pax_q),
		.ay         (pay_q),
		.bx         (pt_rd[C-1:0]),
		.by         (pt_rd[2*C-1:C]),
		.busy       (cmp_busy),
		.seen       (cmp_seen),
		.best       (best)
	);

	cpg_isqrt #(.COORD_BITS(C)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (best),
		.done     (root_done),
		.root     (root)
	);

	assign res_out.valid         = (state_q == ST_OUT);
	assign res_out.min_distance  = dist_q;
	assign res_out.pair_found    = found_q;
	assign res_out.cell_overflow = ovf_q;

	a_nopair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.pair_found |-> res_out.min_distance == '0)
		else $error("distance without pair");
	a_clear_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_hs |=> fvalid_q == '0 && !dropped_q)
		else $error("run state not cleared");
	a_pair_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PBW |-> $past(m_q < nf_q))
		else $error("slot read past fill");
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_vld_q |-> wr_fill_q != '0 && 32'(wr_fill_q) <= CELL_CAP)
		else $error("fill count out of range");
endmodule

// ----- bench/tb_closest_pair_grid_hash.sv -----
// Self-checking bench for closest_pair_grid_hash: drives point beats, predicts the
// grid-search distance (same and neighbor cells) per set and checks result beats in order.
// Depends on cpg_pkg, cpg_if and the closest_pair_grid_hash RTL.
`timescale 1ns / 100ps

module tb_closest_pair_grid_hash;
	import cpg_pkg::*;

	localparam int GMAX = GRID_MAX_DEF;
	localparam int CAP = CELL_CAP_DEF;
	localparam int CB = COORD_BITS_DEF;
	localparam int WATCH_LIMIT = 200000;

	typedef struct packed {
		logic [CB:0] min_distance;
		logic        pair_found;
		logic        cell_overflow;
	} dist_res_t;

	class pair_scoreboard;
		int unsigned side_reg;
		int unsigned fill[GMAX*GMAX];
		logic [CB-1:0] px[GMAX*GMAX*CAP];
		logic [CB-1:0] py[GMAX*GMAX*CAP];
		logic dropped;
		dist_res_t pending[$];
		int errors;

		function new();
			side_reg = SIDE_RESET;
			errors = 0;
			clear_set();
		endfunction

		function void clear_set();
			foreach (fill[i]) fill[i] = 0;
			dropped = 0;
		endfunction

		function longint unsigned root_floor(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function longint unsigned sq_dist(int a, int b);
			longint unsigned dx, dy;
			dx = px[a] >= px[b] ? px[a] - px[b] : px[b] - px[a];
			dy = py[a] >= py[b] ? py[a] - py[b] : py[b] - py[a];
			return dx * dx + dy * dy;
		endfunction

		function void note_point(logic [CB-1:0] x, logic [CB-1:0] y, logic last);
			int unsigned s, cx, cy, c, n;
			longint unsigned best, sq;
			logic seen;
			dist_res_t r;
			s = side_reg == 0 ? 1 : (side_reg > GMAX ? GMAX : side_reg);
			cx = (longint'(x) * s) >> CB;
			cy = (longint'(y) * s) >> CB;
			if (cx >= GMAX) cx = GMAX - 1;
			if (cy >= GMAX) cy = GMAX - 1;
			c = cy * GMAX + cx;
			if (fill[c] >= CAP) begin
				dropped = 1;
			end else begin
				px[c*CAP + fill[c]] = x;
				py[c*CAP + fill[c]] = y;
				fill[c]++;
			end
			if (!last) return;
			best = (64'd1 << (2*CB + 2)) - 1;
			seen = 0;
			for (int ay = 0; ay < GMAX; ay++)
				for (int ax = 0; ax < GMAX; ax++) begin
					int unsigned a;
					a = ay * GMAX + ax;
					for (int k = 0; k < fill[a]; k++) begin
						for (int m = k + 1; m < fill[a]; m++) begin
							sq = sq_dist(a*CAP + k, a*CAP + m);
							seen = 1;
							if (sq < best) best = sq;
						end
						for (int ny = ay - 1; ny <= ay + 1; ny++)
							for (int nx = ax - 1; nx <= ax + 1; nx++) begin
								if (nx < 0 || ny < 0 || nx >= GMAX || ny >= GMAX) continue;
								if (nx == ax && ny == ay) continue;
								n = ny * GMAX + nx;
								for (int m = 0; m < fill[n]; m++) begin
									sq = sq_dist(a*CAP + k, n*CAP + m);
									seen = 1;
									if (sq < best) best = sq;
								end
							end
					end
				end
			r.min_distance = seen ? (CB+1)'(root_floor(best)) : '0;
			r.pair_found = seen;
			r.cell_overflow = dropped;
			pending = {pending, r};
			clear_set();
		endfunction

		function void check_result(dist_res_t got);
			dist_res_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat %p", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.min_distance !== e.min_distance) begin
				$error("min_distance expected %0d actual %0d", e.min_distance, got.min_distance);
				errors++;
			end
			if (got.pair_found !== e.pair_found) begin
				$error("pair_found expected %0d actual %0d", e.pair_found, got.pair_found);
				errors++;
			end
			if (got.cell_overflow !== e.cell_overflow) begin
				$error("cell_overflow expected %0d actual %0d", e.cell_overflow,
					got.cell_overflow);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [SIDE_W-1:0] cfg_wdata = '0;
	int idle_cycles = 0;
	pair_scoreboard sb;

	cpg_pt_if pt ();
	cpg_res_if res ();

	closest_pair_grid_hash dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.pt_in(pt.sink), .res_out(res.source)
	);

	always #5 clk = ~clk;

	initial begin
		pt.valid = 0;
		pt.x_coord = '0;
		pt.y_coord = '0;
		pt.last_point = 0;
		res.ready = 0;
	end

	always @(posedge clk) begin
		if (res.valid && res.ready) sb.check_result({res.min_distance, res.pair_found,
			res.cell_overflow});
		if ((pt.valid && pt.ready) || (res.valid && res.ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// random stall on the result side
	initial begin
		int w;
		@(posedge arst_n);
		while (1) begin
			@(negedge clk);
			w = $urandom_range(0, 3);
			if (w > 0) begin
				res.ready <= 0;
				repeat (w) @(negedge clk);
			end
			res.ready <= 1;
			do @(posedge clk); while (!(res.valid && res.ready));
		end
	end

	task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y, logic last,
			bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 3) : 0;
		if (w > 0) begin
			pt.valid <= 0;
			repeat (w) @(negedge clk);
		end
		pt.valid <= 1;
		pt.x_coord <= x;
		pt.y_coord <= y;
		pt.last_point <= last;
		do @(posedge clk); while (!pt.ready);
		sb.note_point(x, y, last);
		@(negedge clk);
	endtask

	task automatic settle_and_write(logic [SIDE_W-1:0] side);
		pt.valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= side;
		@(negedge clk);
		cfg_we <= 0;
		sb.side_reg = side;
	endtask

	task automatic random_set(int n, bit gaps, bit clustered);
		logic [CB-1:0] bx, by, x, y;
		bx = CB'($urandom);
		by = CB'($urandom);
		for (int i = 0; i < n; i++) begin
			if (clustered) begin
				x = bx + CB'($urandom_range(0, 4095));
				y = by + CB'($urandom_range(0, 4095));
			end else begin
				x = CB'($urandom);
				y = CB'($urandom);
			end
			send_point(x, y, i == n - 1, gaps);
		end
	endtask

	initial begin
		logic [SIDE_W-1:0] sides[6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd9};
		bit gaps;
		sb = new();
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// single point: no pair
		send_point(16'h1234, 16'h5678, 1, 0);
		// corners, widest distance, but in cells that are not neighbors: no pair
		send_point(16'h0000, 16'h0000, 0, 0);
		send_point(16'hFFFF, 16'hFFFF, 1, 0);
		// identical points
		send_point(16'h8000, 16'h8000, 0, 1);
		send_point(16'h8000, 16'h8000, 1, 1);
		settle_and_write(5'd1);
		// one cell overfilled
		for (int i = 0; i < 10; i++)
			send_point(16'(i * 6553), 16'hFFFF - 16'(i * 4000), i == 9, 1);
		settle_and_write(5'd0);
		send_point(16'hAAAA, 16'h5555, 0, 0);
		send_point(16'h5555, 16'hAAAA, 1, 0);

		for (int ph = 0; ph < 6; ph++) begin
			settle_and_write(sides[ph]);
			for (int k = 0; k < 26; k++) begin
				int n;
				n = $urandom_range(0, 7) == 0 ? $urandom_range(1, 40) : $urandom_range(2, 12);
				gaps = ph % 3 != 0 || $urandom_range(0, 1);
				random_set(n, gaps, $urandom_range(0, 2) == 0);
			end
		end
		// a side change inside a set
		settle_and_write(5'd16);
		send_point(16'h0100, 16'h0100, 0, 1);
		pt.valid <= 0;
		repeat (2) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= 5'd2;
		@(negedge clk);
		cfg_we <= 0;
		sb.side_reg = 2;
		send_point(16'h0300, 16'h0200, 1, 1);

		pt.valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
